FILE: hdl/esphv_pkg.sv
package esphv_pkg;

	localparam int HOLD_TIMER_BITS_DEF = 13;
	localparam int CFG_INDEX_W         = 2;
	localparam int CFG_DATA_W          = 13;
	localparam int LEVEL_W             = 8;
	localparam int FORCE_W             = 10;
	localparam int STEP_W              = 8;
	localparam int HOLD_STEP_W         = 8;
	localparam int BASE_W              = 13;

	localparam logic [LEVEL_W-1:0]     LEVEL_MAX        = 8'd255;
	localparam logic [STEP_W-1:0]      STEP_SIZE_RST    = 8'd15;
	localparam logic [FORCE_W-1:0]     FORCE_THRESH_RST = 10'd150;
	localparam logic [HOLD_STEP_W-1:0] HOLD_STEP_RST    = 8'd20;
	localparam logic [BASE_W-1:0]      BASE_HOLD_RST    = 13'd5100;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_STEP_SIZE        = 2'd0,
		REG_FORCE_THRESHOLD  = 2'd1,
		REG_HOLD_MS_PER_STEP = 2'd2,
		REG_BASE_HOLD_MS     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [STEP_W-1:0]      step_size;
		logic [FORCE_W-1:0]     force_threshold;
		logic [HOLD_STEP_W-1:0] hold_ms_per_step;
		logic [BASE_W-1:0]      base_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic               button_level;
		logic               intensity_clk;
		logic               intensity_dt;
		logic               sensitivity_clk;
		logic               sensitivity_dt;
		logic [FORCE_W-1:0] force_a_raw;
		logic [FORCE_W-1:0] force_b_raw;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] vibration_level;
		logic [LEVEL_W-1:0] intensity_led;
		logic [LEVEL_W-1:0] sensitivity_led;
		logic               power_led;
	} out_item_t;

endpackage

FILE: hdl/esphv_if.sv
interface esphv_in_if;
	logic       valid;
	logic       ready;
	logic       button_level;
	logic       intensity_clk;
	logic       intensity_dt;
	logic       sensitivity_clk;
	logic       sensitivity_dt;
	logic [9:0] force_a_raw;
	logic [9:0] force_b_raw;

	modport source (
		output valid, button_level, intensity_clk, intensity_dt,
		output sensitivity_clk, sensitivity_dt, force_a_raw, force_b_raw,
		input  ready
	);
	modport sink (
		input  valid, button_level, intensity_clk, intensity_dt,
		input  sensitivity_clk, sensitivity_dt, force_a_raw, force_b_raw,
		output ready
	);
endinterface

interface esphv_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] vibration_level;
	logic [7:0] intensity_led;
	logic [7:0] sensitivity_led;
	logic       power_led;

	modport source (
		output valid, vibration_level, intensity_led, sensitivity_led, power_led,
		input  ready
	);
	modport sink (
		input  valid, vibration_level, intensity_led, sensitivity_led, power_led,
		output ready
	);
endinterface

FILE: hdl/esphv_cfg.sv
module esphv_cfg import esphv_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size        <= STEP_SIZE_RST;
			cfg_q.force_threshold  <= FORCE_THRESH_RST;
			cfg_q.hold_ms_per_step <= HOLD_STEP_RST;
			cfg_q.base_hold_ms     <= BASE_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STEP_SIZE:        cfg_q.step_size        <= cfg_data[STEP_W-1:0];
				REG_FORCE_THRESHOLD:  cfg_q.force_threshold  <= cfg_data[FORCE_W-1:0];
				REG_HOLD_MS_PER_STEP: cfg_q.hold_ms_per_step <= cfg_data[HOLD_STEP_W-1:0];
				REG_BASE_HOLD_MS:     cfg_q.base_hold_ms     <= cfg_data[BASE_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/esphv_core.sv
module esphv_core import esphv_pkg::*; #(
	parameter int HOLD_TIMER_BITS = HOLD_TIMER_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	localparam int CMP_W = (HOLD_TIMER_BITS > BASE_W) ? HOLD_TIMER_BITS : BASE_W;
	localparam int CUT_W = HOLD_STEP_W + LEVEL_W;

	function automatic logic [LEVEL_W-1:0] knob_step(
		input logic [LEVEL_W-1:0] level,
		input logic [STEP_W-1:0]  step,
		input logic               dt
	);
		logic [LEVEL_W:0] sum;
		logic [LEVEL_W:0] diff;
		sum  = {1'b0, level} + {1'b0, step};
		diff = {1'b0, level} - {1'b0, step};
		if (!dt)
			knob_step = sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
		else
			knob_step = diff[LEVEL_W] ? '0 : diff[LEVEL_W-1:0];
	endfunction

	logic                       active_q, last_button_q, consumed_q;
	logic                       last_iclk_q, last_sclk_q, pressing_q;
	logic [LEVEL_W-1:0]         intensity_q, sensitivity_q, drive_q;
	logic [HOLD_TIMER_BITS-1:0] hold_q;

	logic                       active_d, consumed_d, last_iclk_d, last_sclk_d, pressing_d;
	logic [LEVEL_W-1:0]         intensity_d, sensitivity_d, drive_d;
	logic [HOLD_TIMER_BITS-1:0] hold_d, hold_cur;
	logic                       toggle, press;
	logic [FORCE_W-1:0]         force_a, force_b;
	logic [CUT_W-1:0]           cut;
	logic [BASE_W-1:0]          need;

	always_comb begin
		toggle      = !item.button_level && last_button_q && !consumed_q;
		active_d    = active_q ^ toggle;
		consumed_d  = item.button_level ? 1'b0 : (toggle | consumed_q);
		drive_d     = (toggle && !active_d) ? '0 : drive_q;
		last_iclk_d = last_iclk_q;
		last_sclk_d = last_sclk_q;
		intensity_d   = intensity_q;
		sensitivity_d = sensitivity_q;
		pressing_d  = pressing_q;
		hold_d      = hold_q;
		force_a     = ~item.force_a_raw;
		force_b     = ~item.force_b_raw;
		press       = (force_a > cfg.force_threshold) || (force_b > cfg.force_threshold);
		hold_cur    = pressing_q ? hold_q : '0;
		res         = '0;

		if (active_d) begin
			if (!last_iclk_q && item.intensity_clk)
				intensity_d = knob_step(intensity_q, cfg.step_size, item.intensity_dt);
			if (!last_sclk_q && item.sensitivity_clk)
				sensitivity_d = knob_step(sensitivity_q, cfg.step_size, item.sensitivity_dt);
			last_iclk_d = item.intensity_clk;
			last_sclk_d = item.sensitivity_clk;
		end

		cut  = CUT_W'(cfg.hold_ms_per_step) * CUT_W'(sensitivity_d);
		need = (cut >= CUT_W'(cfg.base_hold_ms)) ? '0
			: BASE_W'(CUT_W'(cfg.base_hold_ms) - cut);

		if (active_d) begin
			if (press) begin
				pressing_d = 1'b1;
				if (CMP_W'(hold_cur) >= CMP_W'(need))
					drive_d = intensity_d;
				hold_d = (&hold_cur) ? hold_cur : hold_cur + 1'b1;
			end else begin
				drive_d    = '0;
				pressing_d = 1'b0;
				hold_d     = '0;
			end
			res.vibration_level = drive_d;
			res.intensity_led   = intensity_d;
			res.sensitivity_led = sensitivity_d;
			res.power_led       = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			last_button_q <= 1'b1;
			consumed_q    <= 1'b0;
			last_iclk_q   <= 1'b1;
			last_sclk_q   <= 1'b1;
			intensity_q   <= '0;
			sensitivity_q <= '0;
			pressing_q    <= 1'b0;
			hold_q        <= '0;
			drive_q       <= '0;
		end else if (adv) begin
			active_q      <= active_d;
			last_button_q <= item.button_level;
			consumed_q    <= consumed_d;
			last_iclk_q   <= last_iclk_d;
			last_sclk_q   <= last_sclk_d;
			intensity_q   <= intensity_d;
			sensitivity_q <= sensitivity_d;
			pressing_q    <= pressing_d;
			hold_q        <= hold_d;
			drive_q       <= drive_d;
		end
	end

endmodule

FILE: hdl/encoder_set_press_hold_vibration.sv
// Haptic press controller, one item per millisecond tick of sampled pins.
// Channel sample (sink): button, two encoder clock/data pairs and two raw
// force samples. Channel result (source): vibration duty, the two LED levels
// and the power LED, exactly one result item per sample item.
// Configuration: write cfg_data to register cfg_index while cfg_we is high
// (0 step size, 1 force threshold, 2 hold ms per step, 3 base hold ms);
// write only while no item is in flight.
// Path: a sample accepted into the sample register is processed by the core
// into the result register when it advances, and offered from there on.
// Throughput: one item per cycle unless result stalls; the controller
// state advances in a single registered pass, sample to result register.
// Stall: while result is held, the result register keeps its item, the
// sample register can still fill once, and sample.ready falls after that.
// Reset: configuration returns to its defaults, the system is off, both
// levels are zero and the pipeline is empty.
module encoder_set_press_hold_vibration import esphv_pkg::*; #(
	parameter int HOLD_TIMER_BITS = HOLD_TIMER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	esphv_in_if.sink               sample,
	esphv_out_if.source            result
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_comb, res_s2;
	logic      valid_s2;
	logic      adv_s2, take;

	assign adv_s2       = valid_s1 && (!valid_s2 || result.ready);
	assign take         = sample.valid && sample.ready;
	assign sample.ready = !valid_s1 || adv_s2;

	esphv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	esphv_core #(
		.HOLD_TIMER_BITS (HOLD_TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv_s2),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (adv_s2)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.button_level    <= sample.button_level;
			item_s1.intensity_clk   <= sample.intensity_clk;
			item_s1.intensity_dt    <= sample.intensity_dt;
			item_s1.sensitivity_clk <= sample.sensitivity_clk;
			item_s1.sensitivity_dt  <= sample.sensitivity_dt;
			item_s1.force_a_raw     <= sample.force_a_raw;
			item_s1.force_b_raw     <= sample.force_b_raw;
		end
		if (adv_s2)
			res_s2 <= res_comb;
	end

	assign result.valid           = valid_s2;
	assign result.vibration_level = res_s2.vibration_level;
	assign result.intensity_led   = res_s2.intensity_led;
	assign result.sensitivity_led = res_s2.sensitivity_led;
	assign result.power_led       = res_s2.power_led;

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.power_led |->
			res_s2.vibration_level == '0 && res_s2.intensity_led == '0
			&& res_s2.sensitivity_led == '0)
		else $error("result while off carries non-zero levels");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> sample.ready)
		else $error("sample stalled with empty result register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1)
		else $error("pending item dropped from sample register");

	a_adv_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> valid_s2)
		else $error("processed item not offered on result");

endmodule
